// ===== src/fragment_depth_test_and_alpha_blend_assert.svh =====
`ifndef FRAGMENT_DEPTH_TEST_AND_ALPHA_BLEND_ASSERT_SVH
`define FRAGMENT_DEPTH_TEST_AND_ALPHA_BLEND_ASSERT_SVH

// Condition and expression hold in the same cycle.
`define FDTAB_ASSERT_IMPLY(name, clk, rst, cond, expr, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error(msg);

// Expression holds in the cycle after the condition.
`define FDTAB_ASSERT_NEXT(name, clk, rst, cond, expr, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error(msg);

`endif

// ===== src/fdtab_pkg.sv =====
package fdtab_pkg;

   localparam int STRIDE_W = 9;
   localparam int SPAN_W   = 17;

   localparam logic [STRIDE_W-1:0] STRIDE_RESET = 9'd256;
   localparam logic [7:0]          DEPTH_FAR    = 8'hFF;
   localparam logic [7:0]          BYTE_MAX     = 8'hFF;

   typedef enum logic [1:0] {
      CSR_DEPTH_TEST = 2'd0,
      CSR_BLEND      = 2'd1,
      CSR_ROW_STRIDE = 2'd2
   } csr_index_type;

   typedef logic [3:0][7:0] color_type;

   typedef struct packed {
      logic [7:0]         pixel_x;
      logic [7:0]         pixel_y;
      logic signed [15:0] frag_depth;
      logic [7:0]         src_c0;
      logic [7:0]         src_c1;
      logic [7:0]         src_c2;
      logic [7:0]         src_alpha;
   } req_type;

   typedef struct packed {
      logic       written;
      logic [7:0] out_c0;
      logic [7:0] out_c1;
      logic [7:0] out_c2;
      logic [7:0] out_alpha;
   } rsp_type;

endpackage

// ===== src/fdtab_blend.sv =====
module fdtab_blend (
   input  logic                 clock,
   input  logic                 load,
   input  logic                 blend_on,
   input  fdtab_pkg::color_type src,
   input  fdtab_pkg::color_type dst,
   output fdtab_pkg::color_type res
);
   import fdtab_pkg::*;

   logic [3:0][15:0] src_prod_ff;
   logic [3:0][15:0] src_prod_in;
   logic [3:0][15:0] dst_prod_ff;
   logic [3:0][15:0] dst_prod_in;
   logic             blend_ff;
   color_type        src_ff;
   logic [7:0]       inv_alpha;

   // Exact floor(p / 255) for any product of two bytes.
   function automatic logic [7:0] div255(input logic [15:0] p);
      logic [16:0] sum;
      sum = 17'(p) + 17'(p[15:8]) + 17'd1;
      return sum[15:8];
   endfunction

   assign inv_alpha = BYTE_MAX - src[3];

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         src_prod_in[k] = 16'(src[k]) * 16'(src[3]);
         dst_prod_in[k] = 16'(dst[k]) * 16'(inv_alpha);
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         src_prod_ff <= src_prod_in;
         dst_prod_ff <= dst_prod_in;
         blend_ff    <= blend_on;
         src_ff      <= src;
      end
   end

   always_comb begin
      if (blend_ff) begin
         for (int k = 0; k < 4; k++) begin
            res[k] = div255(src_prod_ff[k]) + div255(dst_prod_ff[k]);
         end
      end else begin
         res = {BYTE_MAX, src_ff[2], src_ff[1], src_ff[0]};
      end
   end

endmodule

// ===== src/fragment_depth_test_and_alpha_blend.sv =====
// Raster output stage: depth test and source-alpha blend against on-chip stores.
// A fragment transfers on req when req_valid and req_ready are high; its single
// result transfers on rsp when rsp_valid and rsp_ready are high. Configuration
// registers are written through csr_we, csr_index and csr_wdata with no wait.
// A fragment's result passes stages s1, s2, s3 and the output register, and one
// fragment is taken per cycle unless a hazard or an output stall holds s1. Both
// memories are read at the address in s1, ahead of the write-back; a fragment
// that hits the same pixel as either of the two fragments ahead of it waits in
// s1. After reset the block clears all BUF_WIDTH*BUF_HEIGHT entries (65536 by
// default) of both memories, one entry per cycle; req_ready stays low during
// that pass while configuration writes are still taken. When the receiver holds
// rsp_ready low while rsp_valid is high, the whole pipeline holds in place and
// req_ready drops as soon as the entry stage is occupied.
module fragment_depth_test_and_alpha_blend #(
   parameter int BUF_WIDTH  = 256,
   parameter int BUF_HEIGHT = 256
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  fdtab_pkg::req_type                 req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output fdtab_pkg::rsp_type                 rsp_data,
   input  logic                               csr_we,
   input  logic [1:0]                         csr_index,
   input  logic [fdtab_pkg::STRIDE_W-1:0]     csr_wdata
);
   import fdtab_pkg::*;

   localparam int STORE_SIZE = BUF_WIDTH * BUF_HEIGHT;
   localparam int ADDR_W     = (STORE_SIZE > 1) ? $clog2(STORE_SIZE) : 1;
   localparam int SIZE_W     = $clog2(STORE_SIZE + 1);
   localparam int CMP_W      = (SIZE_W > SPAN_W) ? SIZE_W : SPAN_W;

   typedef struct packed {
      logic              ok;
      logic [ADDR_W-1:0] addr;
      logic [7:0]        depth;
      color_type         src;
   } stage_type;

   typedef struct packed {
      logic              pass;
      logic [ADDR_W-1:0] addr;
   } wb_type;

   logic [7:0]        depth_mem [STORE_SIZE];
   color_type         color_mem [STORE_SIZE];
   logic [7:0]        depth_rd_ff;
   color_type         color_rd_ff;

   logic              depth_test_ff;
   logic              blend_ff;
   logic [STRIDE_W-1:0] stride_ff;

   logic              clearing_ff;
   logic [ADDR_W-1:0] clr_addr_ff;

   logic              s1_valid_ff;
   logic              s2_valid_ff;
   logic              s3_valid_ff;
   stage_type         s1_ff;
   stage_type         s1_in;
   stage_type         s2_ff;
   wb_type            s3_ff;
   logic              rsp_valid_ff;
   rsp_type           rsp_data_ff;

   logic [SPAN_W-1:0] span;
   logic [CMP_W-1:0]  span_ext;
   logic              move;
   logic              hazard;
   logic              s1_go;
   logic              req_fire;
   logic              pass2;
   logic              depth_we;
   logic              color_we;
   logic [ADDR_W-1:0] rd_addr;
   color_type         blend_res;

   assign span     = SPAN_W'(req_data.pixel_y) * SPAN_W'(stride_ff) + SPAN_W'(req_data.pixel_x);
   assign span_ext = CMP_W'(span);

   always_comb begin
      s1_in.ok    = (req_data.frag_depth[15:8] == 8'd0) && (span_ext < CMP_W'(STORE_SIZE));
      s1_in.addr  = span_ext[ADDR_W-1:0];
      s1_in.depth = req_data.frag_depth[7:0];
      s1_in.src   = {req_data.src_alpha, req_data.src_c2, req_data.src_c1, req_data.src_c0};
   end

   assign move   = !rsp_valid_ff || rsp_ready;
   assign hazard = s1_valid_ff &&
                   ((s2_valid_ff && s2_ff.ok && (s2_ff.addr == s1_ff.addr)) ||
                    (s3_valid_ff && s3_ff.pass && (s3_ff.addr == s1_ff.addr)));
   assign s1_go     = move && !hazard;
   assign req_ready = !clearing_ff && (!s1_valid_ff || s1_go);
   assign req_fire  = req_valid && req_ready;

   assign pass2    = s2_valid_ff && s2_ff.ok && (!depth_test_ff || (depth_rd_ff > s2_ff.depth));
   assign depth_we = move && pass2 && depth_test_ff;
   assign color_we = move && s3_valid_ff && s3_ff.pass;
   assign rd_addr  = move ? s1_ff.addr : s2_ff.addr;

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_test_ff <= 1'b1;
         blend_ff      <= 1'b0;
         stride_ff     <= STRIDE_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_DEPTH_TEST: depth_test_ff <= csr_wdata[0];
            CSR_BLEND:      blend_ff      <= csr_wdata[0];
            CSR_ROW_STRIDE: stride_ff     <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clearing_ff) begin
         if (clr_addr_ff == ADDR_W'(STORE_SIZE - 1)) begin
            clearing_ff <= 1'b0;
         end
         clr_addr_ff <= clr_addr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_fire) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_go) begin
            s1_valid_ff <= 1'b0;
         end
         if (move) begin
            s2_valid_ff  <= s1_valid_ff && !hazard;
            s3_valid_ff  <= s2_valid_ff;
            rsp_valid_ff <= s3_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_ff <= s1_in;
      end
      if (move) begin
         s2_ff      <= s1_ff;
         s3_ff.pass <= pass2;
         s3_ff.addr <= s2_ff.addr;
         rsp_data_ff.written   <= s3_ff.pass;
         rsp_data_ff.out_c0    <= s3_ff.pass ? blend_res[0] : 8'd0;
         rsp_data_ff.out_c1    <= s3_ff.pass ? blend_res[1] : 8'd0;
         rsp_data_ff.out_c2    <= s3_ff.pass ? blend_res[2] : 8'd0;
         rsp_data_ff.out_alpha <= s3_ff.pass ? blend_res[3] : 8'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (clearing_ff) begin
         depth_mem[clr_addr_ff] <= DEPTH_FAR;
      end else if (depth_we && !reset) begin
         depth_mem[s2_ff.addr] <= s2_ff.depth;
      end
      depth_rd_ff <= depth_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (clearing_ff) begin
         color_mem[clr_addr_ff] <= '0;
      end else if (color_we && !reset) begin
         color_mem[s3_ff.addr] <= blend_res;
      end
      color_rd_ff <= color_mem[rd_addr];
   end

   fdtab_blend u_blend (
      .clock    (clock),
      .load     (move),
      .blend_on (blend_ff),
      .src      (s2_ff.src),
      .dst      (color_rd_ff),
      .res      (blend_res)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`include "fragment_depth_test_and_alpha_blend_assert.svh"

   `FDTAB_ASSERT_IMPLY(a_no_transfer_while_clearing, clock, reset,
      clearing_ff, !req_ready, "req_ready high during clearing pass")
   `FDTAB_ASSERT_IMPLY(a_no_same_pixel_overlap, clock, reset,
      s2_valid_ff && s3_valid_ff && s3_ff.pass, s2_ff.addr != s3_ff.addr,
      "read stage overlaps pending write-back to same pixel")
   `FDTAB_ASSERT_IMPLY(a_discard_is_zero, clock, reset,
      rsp_valid && !rsp_data.written,
      (rsp_data.out_c0 == 8'd0) && (rsp_data.out_c1 == 8'd0) &&
      (rsp_data.out_c2 == 8'd0) && (rsp_data.out_alpha == 8'd0),
      "discarded fragment carries nonzero color")
   `FDTAB_ASSERT_IMPLY(a_opaque_alpha, clock, reset,
      rsp_valid && rsp_data.written && !blend_ff, rsp_data.out_alpha == BYTE_MAX,
      "unblended write without full alpha")
   `FDTAB_ASSERT_NEXT(a_stall_holds_result, clock, reset,
      rsp_valid && !rsp_ready, rsp_valid && $stable(s3_valid_ff) && $stable(s3_ff),
      "pipeline moved while result stalled")

endmodule
